// ===== rtl/aamc_pkg.sv =====
// ----------------------------------------------------------------------------
// aamc_pkg
// Shared widths, category codes, mode numbers and encoding class patterns of
// the addressing-mode classifier.
// ----------------------------------------------------------------------------
package aamc_pkg;

  localparam int KIND_W  = 4;
  localparam int WORD_W  = 32;
  localparam int MODE_W  = 6;

  // Category selector codes
  localparam logic [KIND_W-1:0] KIND_DATA       = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LS         = 4'd1;
  localparam logic [KIND_W-1:0] KIND_LSM        = 4'd2;
  localparam logic [KIND_W-1:0] KIND_MISC       = 4'd3;
  localparam logic [KIND_W-1:0] KIND_COPROC     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_VFP_S      = 4'd5;
  localparam logic [KIND_W-1:0] KIND_VFP_S_MON  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_VFP_D      = 4'd7;
  localparam logic [KIND_W-1:0] KIND_VFP_D_MON  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_VFP_LSM    = 4'd9;

  // Mode numbers
  localparam logic [MODE_W-1:0] MODE_UNKNOWN       = 6'd0;
  localparam logic [MODE_W-1:0] MODE_LS_IMM        = 6'd1;
  localparam logic [MODE_W-1:0] MODE_LS_IMM_PRE    = 6'd2;
  localparam logic [MODE_W-1:0] MODE_LS_IMM_POST   = 6'd3;
  localparam logic [MODE_W-1:0] MODE_LS_REG        = 6'd4;
  localparam logic [MODE_W-1:0] MODE_LS_REG_PRE    = 6'd10;
  localparam logic [MODE_W-1:0] MODE_LS_REG_POST   = 6'd16;
  localparam logic [MODE_W-1:0] MODE_DP_IMM        = 6'd22;
  localparam logic [MODE_W-1:0] MODE_DP_RRX        = 6'd23;
  localparam logic [MODE_W-1:0] MODE_DP_REG        = 6'd24;
  localparam logic [MODE_W-1:0] MODE_DP_IMM_SHIFT  = 6'd25;
  localparam logic [MODE_W-1:0] MODE_DP_REG_SHIFT  = 6'd29;
  localparam logic [MODE_W-1:0] MODE_LSM_IA        = 6'd33;
  localparam logic [MODE_W-1:0] MODE_LSM_IB        = 6'd34;
  localparam logic [MODE_W-1:0] MODE_LSM_DA        = 6'd35;
  localparam logic [MODE_W-1:0] MODE_LSM_DB        = 6'd36;
  localparam logic [MODE_W-1:0] MODE_MISC_IMM      = 6'd37;
  localparam logic [MODE_W-1:0] MODE_MISC_REG      = 6'd38;
  localparam logic [MODE_W-1:0] MODE_MISC_IMM_PRE  = 6'd39;
  localparam logic [MODE_W-1:0] MODE_MISC_REG_PRE  = 6'd40;
  localparam logic [MODE_W-1:0] MODE_MISC_IMM_POST = 6'd41;
  localparam logic [MODE_W-1:0] MODE_MISC_REG_POST = 6'd42;
  localparam logic [MODE_W-1:0] MODE_CP_IMM        = 6'd43;
  localparam logic [MODE_W-1:0] MODE_CP_IMM_PRE    = 6'd44;
  localparam logic [MODE_W-1:0] MODE_CP_IMM_POST   = 6'd45;
  localparam logic [MODE_W-1:0] MODE_CP_UNINDEXED  = 6'd46;
  localparam logic [MODE_W-1:0] MODE_VFP_S_BASE    = 6'd47;
  localparam logic [MODE_W-1:0] MODE_VFP_S_MON_BASE = 6'd50;
  localparam logic [MODE_W-1:0] MODE_VFP_D_BASE    = 6'd53;
  localparam logic [MODE_W-1:0] MODE_VFP_D_MON_BASE = 6'd56;
  localparam logic [MODE_W-1:0] MODE_VFP_LSM_UNIDX = 6'd59;
  localparam logic [MODE_W-1:0] MODE_VFP_LSM_INC   = 6'd60;
  localparam logic [MODE_W-1:0] MODE_VFP_LSM_DEC   = 6'd61;
  localparam logic [MODE_W-1:0] MODE_LAST          = 6'd61;

  // Encoding class patterns
  localparam logic [4:0] VFP_LSM_INC_PAT = 5'b11001;
  localparam logic [4:0] VFP_LSM_DEC_PAT = 5'b11010;
  localparam logic [2:0] CP_CLASS_PAT    = 3'b110;
  localparam logic [2:0] SCALED_ROR      = 3'b111;
  localparam logic [2:0] LSM_CLASS_PAT   = 3'b100;

endpackage

// ===== rtl/arm_addressing_mode_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// arm_addressing_mode_classifier_unit
// Classifies the operand / addressing mode of one ARM instruction word.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive kind and instr_word and raise start. The request
//   is taken at a rising edge where start is high and busy is low. busy is
//   high in reset and in the cycle after it; from then on a request can be
//   taken in every cycle.
//   Result channel: mode is valid for exactly one cycle while done is high.
//   The receiver has no way to stall, so each result must be taken in the
//   cycle it is shown.
//   Path: a request taken at a rising edge lands in the input register; the
//   classifier output is then captured in the result register, which also
//   raises done. Throughput: one request per cycle, set by the single
//   register-to-register pass through the decode logic.
//   Reset: rst is synchronous; it drops all requests in flight and clears
//   done. Mode 0 means the word is not in the selected class.
// ----------------------------------------------------------------------------
module arm_addressing_mode_classifier_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [aamc_pkg::KIND_W-1:0] kind,
  input  logic [aamc_pkg::WORD_W-1:0] instr_word,
  output logic                        done,
  output logic [aamc_pkg::MODE_W-1:0] mode
);

  logic                        accept;
  logic                        in_valid;
  logic [aamc_pkg::KIND_W-1:0] kind_q;
  logic [aamc_pkg::WORD_W-1:0] word_q;
  logic [aamc_pkg::MODE_W-1:0] mode_next;

  assign accept = start && !busy;

  // Hold busy in reset and the cycle after it, then open the request side.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Input register: capture the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      word_q <= instr_word;
    end
  end

  aamc_decode u_decode (
    .kind       (kind_q),
    .instr_word (word_q),
    .mode       (mode_next)
  );

  // Result register: advance the classification and strobe done.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      mode <= mode_next;
    end
  end

`ifndef SYNTH
  a_accept_to_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_valid)
    else $error("accepted request did not reach the input register");

  a_stage_to_done: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("staged request did not produce a result");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !in_valid |=> !done)
    else $error("result strobe without a staged request");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (mode <= aamc_pkg::MODE_LAST))
    else $error("mode number out of range");

  a_bad_kind: assert property (@(posedge clk) disable iff (rst)
    (in_valid && kind_q > aamc_pkg::KIND_VFP_LSM) |=>
      (mode == aamc_pkg::MODE_UNKNOWN))
    else $error("unknown category gave a nonzero mode");
`endif

endmodule

// ===== rtl/aamc_decode.sv =====
// ----------------------------------------------------------------------------
// aamc_decode
// Combinational classifier: maps a category and instruction word to a mode.
// ----------------------------------------------------------------------------
module aamc_decode (
  input  logic [aamc_pkg::KIND_W-1:0] kind,
  input  logic [aamc_pkg::WORD_W-1:0] instr_word,
  output logic [aamc_pkg::MODE_W-1:0] mode
);

  function automatic logic [aamc_pkg::MODE_W-1:0] f_data(
    input logic [aamc_pkg::WORD_W-1:0] w
  );
    logic [aamc_pkg::MODE_W-1:0] sh;
    sh = {4'b0000, w[6:5]};
    if (w[27:26] != 2'b00) begin
      return aamc_pkg::MODE_UNKNOWN;
    end else if (w[25]) begin
      return aamc_pkg::MODE_DP_IMM;
    end else if (w[11:4] == 8'h06) begin
      return aamc_pkg::MODE_DP_RRX;
    end else if (!w[4]) begin
      if (w[11:5] == 7'd0) begin
        return aamc_pkg::MODE_DP_REG;
      end
      return aamc_pkg::MODE_DP_IMM_SHIFT + sh;
    end else if (!w[7]) begin
      return aamc_pkg::MODE_DP_REG_SHIFT + sh;
    end
    return aamc_pkg::MODE_UNKNOWN;
  endfunction

  function automatic logic [aamc_pkg::MODE_W-1:0] f_ls(
    input logic [aamc_pkg::WORD_W-1:0] w
  );
    logic [aamc_pkg::MODE_W-1:0] base;
    logic [2:0]                  sel;
    sel  = {w[25], w[24], w[21]};
    base = aamc_pkg::MODE_UNKNOWN;
    if (w[27:26] != 2'b01) begin
      return aamc_pkg::MODE_UNKNOWN;
    end
    unique case (sel)
      3'd2: return aamc_pkg::MODE_LS_IMM;
      3'd3: return aamc_pkg::MODE_LS_IMM_PRE;
      3'd0: return aamc_pkg::MODE_LS_IMM_POST;
      3'd6: base = aamc_pkg::MODE_LS_REG;
      3'd7: base = aamc_pkg::MODE_LS_REG_PRE;
      3'd4: base = aamc_pkg::MODE_LS_REG_POST;
      default: return aamc_pkg::MODE_UNKNOWN;
    endcase
    if (w[11:4] == 8'd0) begin
      return base;
    end else if (w[4]) begin
      return aamc_pkg::MODE_UNKNOWN;
    end else if (w[6:5] == 2'b11) begin
      // ROR by zero is RRX
      return (w[11:7] == 5'd0) ? base + 6'd4 : base + 6'd5;
    end
    return base + 6'd1 + {4'b0000, w[6:5]};
  endfunction

  function automatic logic [aamc_pkg::MODE_W-1:0] f_lsm(
    input logic [aamc_pkg::WORD_W-1:0] w
  );
    if (w[27:25] != aamc_pkg::LSM_CLASS_PAT) begin
      return aamc_pkg::MODE_UNKNOWN;
    end
    unique case (w[24:23])
      2'd0: return aamc_pkg::MODE_LSM_DA;
      2'd1: return aamc_pkg::MODE_LSM_IA;
      2'd2: return aamc_pkg::MODE_LSM_DB;
      default: return aamc_pkg::MODE_LSM_IB;
    endcase
  endfunction

  function automatic logic [aamc_pkg::MODE_W-1:0] f_misc(
    input logic [aamc_pkg::WORD_W-1:0] w
  );
    if (w[27:25] != 3'b000 || !w[7] || !w[4]) begin
      return aamc_pkg::MODE_UNKNOWN;
    end
    unique case ({w[24], w[22], w[21]})
      3'd0: return aamc_pkg::MODE_MISC_REG_POST;
      3'd2: return aamc_pkg::MODE_MISC_IMM_POST;
      3'd4: return aamc_pkg::MODE_MISC_REG;
      3'd5: return aamc_pkg::MODE_MISC_REG_PRE;
      3'd6: return aamc_pkg::MODE_MISC_IMM;
      3'd7: return aamc_pkg::MODE_MISC_IMM_PRE;
      default: return aamc_pkg::MODE_UNKNOWN;
    endcase
  endfunction

  function automatic logic [aamc_pkg::MODE_W-1:0] f_coproc(
    input logic [aamc_pkg::WORD_W-1:0] w
  );
    if (w[27:25] != aamc_pkg::CP_CLASS_PAT) begin
      return aamc_pkg::MODE_UNKNOWN;
    end
    unique case ({w[24], w[22]})
      2'd0: return aamc_pkg::MODE_CP_UNINDEXED;
      2'd1: return aamc_pkg::MODE_CP_IMM_POST;
      2'd2: return aamc_pkg::MODE_CP_IMM;
      default: return aamc_pkg::MODE_CP_IMM_PRE;
    endcase
  endfunction

  function automatic logic [aamc_pkg::MODE_W-1:0] f_bank(
    input logic [aamc_pkg::WORD_W-1:0] w,
    input logic [aamc_pkg::MODE_W-1:0] base
  );
    if (w[15:14] == 2'd0) begin
      return base;
    end else if (w[3:2] == 2'd0) begin
      return base + 6'd1;
    end
    return base + 6'd2;
  endfunction

  function automatic logic [aamc_pkg::MODE_W-1:0] f_vfp_lsm(
    input logic [aamc_pkg::WORD_W-1:0] w
  );
    if (w[27:23] == aamc_pkg::VFP_LSM_INC_PAT) begin
      return w[21] ? aamc_pkg::MODE_VFP_LSM_INC : aamc_pkg::MODE_VFP_LSM_UNIDX;
    end else if (w[27:23] == aamc_pkg::VFP_LSM_DEC_PAT && w[21]) begin
      return aamc_pkg::MODE_VFP_LSM_DEC;
    end
    return aamc_pkg::MODE_UNKNOWN;
  endfunction

  always_comb begin
    unique case (kind)
      aamc_pkg::KIND_DATA:      mode = f_data(instr_word);
      aamc_pkg::KIND_LS:        mode = f_ls(instr_word);
      aamc_pkg::KIND_LSM:       mode = f_lsm(instr_word);
      aamc_pkg::KIND_MISC:      mode = f_misc(instr_word);
      aamc_pkg::KIND_COPROC:    mode = f_coproc(instr_word);
      aamc_pkg::KIND_VFP_S:     mode = f_bank(instr_word, aamc_pkg::MODE_VFP_S_BASE);
      aamc_pkg::KIND_VFP_S_MON: mode = f_bank(instr_word, aamc_pkg::MODE_VFP_S_MON_BASE);
      aamc_pkg::KIND_VFP_D:     mode = f_bank(instr_word, aamc_pkg::MODE_VFP_D_BASE);
      aamc_pkg::KIND_VFP_D_MON: mode = f_bank(instr_word, aamc_pkg::MODE_VFP_D_MON_BASE);
      aamc_pkg::KIND_VFP_LSM:   mode = f_vfp_lsm(instr_word);
      default:                  mode = aamc_pkg::MODE_UNKNOWN;
    endcase
  end

endmodule

// ===== bench/arm_addressing_mode_classifier_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_addressing_mode_classifier_unit_test
// Self-checking bench for the addressing-mode classifier. A short table of
// hand-picked words covers every category but VFP_S_MON, every mode family
// and the rejection rules. A long run of random words follows, mostly
// shaped to sit inside the selected encoding class. Each result on done is
// compared with a typed mode or, if none, with the local model's mode.
// ----------------------------------------------------------------------------
module arm_addressing_mode_classifier_unit_test;

  // Selector values with no category of their own
  localparam logic [aamc_pkg::KIND_W-1:0] KIND_FIRST_UNUSED = 4'd10;
  localparam logic [aamc_pkg::KIND_W-1:0] KIND_MAX          = 4'd15;

  // Shift type field, bits 6..5
  localparam logic [1:0] SHIFT_ROR = 2'b11;

  // Offsets of the scaled RRX and ROR modes from a load/store register base
  localparam logic [aamc_pkg::MODE_W-1:0] LS_OFS_RRX = 6'd4;
  localparam logic [aamc_pkg::MODE_W-1:0] LS_OFS_ROR = 6'd5;

  // Bits 11..4 of a data-processing word that select RRX
  localparam logic [7:0] DP_RRX_FIELD = 8'h06;

  localparam int DIRECTED_COUNT = 26;
  localparam int RANDOM_ITEMS   = 1424;
  localparam int MAX_GAP        = 16;
  localparam int DRAIN_EVERY    = 400;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [aamc_pkg::KIND_W-1:0] kind;
    logic [aamc_pkg::WORD_W-1:0] word;
    bit                          typed;
    logic [aamc_pkg::MODE_W-1:0] mode;
  } stim_row_t;

  typedef struct {
    logic [aamc_pkg::KIND_W-1:0] kind;
    logic [aamc_pkg::WORD_W-1:0] word;
    logic [aamc_pkg::MODE_W-1:0] mode;
  } mode_expect_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [aamc_pkg::KIND_W-1:0] kind;
  logic [aamc_pkg::WORD_W-1:0] instr_word;
  logic                        done;
  logic [aamc_pkg::MODE_W-1:0] mode;

  // Typed-in expectation travelling with the request currently driven
  bit                          row_typed;
  logic [aamc_pkg::MODE_W-1:0] row_mode;

  stim_row_t    directed_rows [DIRECTED_COUNT];
  mode_expect_t expected_modes [$];
  int           mismatch_count;
  int           idle_cycles;

  arm_addressing_mode_classifier_unit dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .instr_word (instr_word),
    .done       (done),
    .mode       (mode)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Mode predictor: classify one word under one category selector.
  // --------------------------------------------------------------------------
  function automatic logic [aamc_pkg::MODE_W-1:0] classify_mode(
    input logic [aamc_pkg::KIND_W-1:0] k,
    input logic [aamc_pkg::WORD_W-1:0] w
  );
    logic [aamc_pkg::MODE_W-1:0] base;
    logic [aamc_pkg::MODE_W-1:0] sh6;
    logic [1:0]                  sh;
    begin
      classify_mode = aamc_pkg::MODE_UNKNOWN;
      base = aamc_pkg::MODE_UNKNOWN;
      sh = w[6:5];
      sh6 = {4'b0000, sh};
      case (k)
        aamc_pkg::KIND_DATA: begin
          if (w[27:26] != 2'b00) begin
            classify_mode = aamc_pkg::MODE_UNKNOWN;
          end else if (w[25]) begin
            classify_mode = aamc_pkg::MODE_DP_IMM;
          end else if (w[11:4] == DP_RRX_FIELD) begin
            classify_mode = aamc_pkg::MODE_DP_RRX;
          end else if (!w[4]) begin
            if (w[11:5] == 7'd0) begin
              classify_mode = aamc_pkg::MODE_DP_REG;
            end else begin
              classify_mode = aamc_pkg::MODE_DP_IMM_SHIFT + sh6;
            end
          end else if (!w[7]) begin
            classify_mode = aamc_pkg::MODE_DP_REG_SHIFT + sh6;
          end
          // register shift with bit 7 set stays unknown
        end
        aamc_pkg::KIND_LS: begin
          if (w[27:26] == 2'b01) begin
            // select on {I, P, W}; post-indexed with writeback is rejected
            case ({w[25], w[24], w[21]})
              3'b010:  classify_mode = aamc_pkg::MODE_LS_IMM;
              3'b011:  classify_mode = aamc_pkg::MODE_LS_IMM_PRE;
              3'b000:  classify_mode = aamc_pkg::MODE_LS_IMM_POST;
              3'b110:  base = aamc_pkg::MODE_LS_REG;
              3'b111:  base = aamc_pkg::MODE_LS_REG_PRE;
              3'b100:  base = aamc_pkg::MODE_LS_REG_POST;
              default: classify_mode = aamc_pkg::MODE_UNKNOWN;
            endcase
            if (base != aamc_pkg::MODE_UNKNOWN) begin
              if (w[11:4] == 8'd0) begin
                classify_mode = base;
              end else if (!w[4]) begin
                // ROR by zero is really RRX
                if (sh == SHIFT_ROR) begin
                  classify_mode = (w[11:7] == 5'd0) ? base + LS_OFS_RRX : base + LS_OFS_ROR;
                end else begin
                  classify_mode = base + 6'd1 + sh6;
                end
              end
            end
          end
        end
        aamc_pkg::KIND_LSM: begin
          if (w[27:25] == aamc_pkg::LSM_CLASS_PAT) begin
            case (w[24:23])
              2'b00: classify_mode = aamc_pkg::MODE_LSM_DA;
              2'b01: classify_mode = aamc_pkg::MODE_LSM_IA;
              2'b10: classify_mode = aamc_pkg::MODE_LSM_DB;
              2'b11: classify_mode = aamc_pkg::MODE_LSM_IB;
            endcase
          end
        end
        aamc_pkg::KIND_MISC: begin
          if (w[27:25] == 3'b000 && w[7] && w[4]) begin
            // select on {P, I, W}
            case ({w[24], w[22], w[21]})
              3'b000:  classify_mode = aamc_pkg::MODE_MISC_REG_POST;
              3'b010:  classify_mode = aamc_pkg::MODE_MISC_IMM_POST;
              3'b100:  classify_mode = aamc_pkg::MODE_MISC_REG;
              3'b101:  classify_mode = aamc_pkg::MODE_MISC_REG_PRE;
              3'b110:  classify_mode = aamc_pkg::MODE_MISC_IMM;
              3'b111:  classify_mode = aamc_pkg::MODE_MISC_IMM_PRE;
              default: classify_mode = aamc_pkg::MODE_UNKNOWN;
            endcase
          end
        end
        aamc_pkg::KIND_COPROC: begin
          if (w[27:25] == aamc_pkg::CP_CLASS_PAT) begin
            case ({w[24], w[22]})
              2'b00: classify_mode = aamc_pkg::MODE_CP_UNINDEXED;
              2'b01: classify_mode = aamc_pkg::MODE_CP_IMM_POST;
              2'b10: classify_mode = aamc_pkg::MODE_CP_IMM;
              2'b11: classify_mode = aamc_pkg::MODE_CP_IMM_PRE;
            endcase
          end
        end
        aamc_pkg::KIND_VFP_S, aamc_pkg::KIND_VFP_S_MON,
        aamc_pkg::KIND_VFP_D, aamc_pkg::KIND_VFP_D_MON: begin
          base = (k == aamc_pkg::KIND_VFP_S)     ? aamc_pkg::MODE_VFP_S_BASE :
                 (k == aamc_pkg::KIND_VFP_S_MON) ? aamc_pkg::MODE_VFP_S_MON_BASE :
                 (k == aamc_pkg::KIND_VFP_D)     ? aamc_pkg::MODE_VFP_D_BASE :
                                                   aamc_pkg::MODE_VFP_D_MON_BASE;
          if (w[15:14] == 2'b00) begin
            classify_mode = base;
          end else if (w[3:2] == 2'b00) begin
            classify_mode = base + 6'd1;
          end else begin
            classify_mode = base + 6'd2;
          end
        end
        aamc_pkg::KIND_VFP_LSM: begin
          if (w[27:23] == aamc_pkg::VFP_LSM_INC_PAT) begin
            classify_mode = w[21] ? aamc_pkg::MODE_VFP_LSM_INC : aamc_pkg::MODE_VFP_LSM_UNIDX;
          end else if (w[27:23] == aamc_pkg::VFP_LSM_DEC_PAT && w[21]) begin
            classify_mode = aamc_pkg::MODE_VFP_LSM_DEC;
          end
        end
        default: classify_mode = aamc_pkg::MODE_UNKNOWN;
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drive one request. Called at a falling edge; returns at the falling edge
  // after the request was taken, with start still high.
  // --------------------------------------------------------------------------
  task automatic drive_request(input logic [aamc_pkg::KIND_W-1:0] k,
                               input logic [aamc_pkg::WORD_W-1:0] w,
                               input bit typed,
                               input logic [aamc_pkg::MODE_W-1:0] m,
                               input int gap);
    begin
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      start      <= 1'b1;
      kind       <= k;
      instr_word <= w;
      row_typed  <= typed;
      row_mode   <= m;
      // hold the request until busy is low at a rising edge
      @(posedge clk);
      while (busy !== 1'b0) @(posedge clk);
      @(negedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: record taken requests, check results, watch for a hang.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    mode_expect_t head;
    mode_expect_t entry;
    bit           progress;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      progress = 1'b0;
      // check the result first, against the oldest recorded request
      if (done === 1'b1) begin
        progress = 1'b1;
        if (expected_modes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result: mode %0d with no request pending", mode);
          end
        end else begin
          head = expected_modes.pop_front();
          if (mode !== head.mode) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mode mismatch: kind %0d word %h expected %0d got %0d",
                       head.kind, head.word, head.mode, mode);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        progress   = 1'b1;
        entry.kind = kind;
        entry.word = instr_word;
        entry.mode = row_typed ? row_mode : classify_mode(kind, instr_word);
        expected_modes.push_back(entry);
      end
      if (progress) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result for %0d cycles", idle_cycles);
        $display("arm_addressing_mode_classifier_unit_test: errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [aamc_pkg::KIND_W-1:0] k;
    logic [aamc_pkg::WORD_W-1:0] w;
    bit                          no_idle;
    int                          gap;

    mismatch_count = 0;
    idle_cycles    = 0;
    rst        = 1'b1;
    start      = 1'b0;
    kind       = aamc_pkg::KIND_DATA;
    instr_word = '0;
    row_typed  = 1'b0;
    row_mode   = aamc_pkg::MODE_UNKNOWN;
    no_idle    = 1'b0;

    // Directed table: typed modes only where they are plain to see
    directed_rows = '{
      '{aamc_pkg::KIND_DATA,      32'h0000_0000, 1'b1, aamc_pkg::MODE_DP_REG},
      '{aamc_pkg::KIND_DATA,      32'hFFFF_FFFF, 1'b1, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_DATA,      32'h0200_0000, 1'b1, aamc_pkg::MODE_DP_IMM},
      '{aamc_pkg::KIND_DATA,      32'h0000_0060, 1'b1, aamc_pkg::MODE_DP_RRX},
      '{aamc_pkg::KIND_DATA,      32'h0000_0F40, 1'b0, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_DATA,      32'h0000_0090, 1'b1, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_LS,        32'h0400_0000, 1'b1, aamc_pkg::MODE_LS_IMM_POST},
      '{aamc_pkg::KIND_LS,        32'h0420_0000, 1'b1, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_LS,        32'h0780_0000, 1'b1, aamc_pkg::MODE_LS_REG},
      '{aamc_pkg::KIND_LS,        32'h0780_0010, 1'b1, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_LS,        32'h07A0_0060, 1'b0, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_LSM,       32'h0800_0000, 1'b1, aamc_pkg::MODE_LSM_DA},
      '{aamc_pkg::KIND_LSM,       32'h0980_0000, 1'b1, aamc_pkg::MODE_LSM_IB},
      '{aamc_pkg::KIND_MISC,      32'h0000_0090, 1'b0, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_MISC,      32'h0020_0090, 1'b1, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_MISC,      32'h01E0_0090, 1'b0, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_COPROC,    32'h0C00_0000, 1'b1, aamc_pkg::MODE_CP_UNINDEXED},
      '{aamc_pkg::KIND_COPROC,    32'h0D40_0000, 1'b0, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_VFP_S,     32'h0000_0000, 1'b1, aamc_pkg::MODE_VFP_S_BASE},
      '{aamc_pkg::KIND_VFP_D,     32'h0000_C00C, 1'b0, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_VFP_D_MON, 32'hFFFF_FFFF, 1'b0, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_VFP_LSM,   32'h0C80_0000, 1'b1, aamc_pkg::MODE_VFP_LSM_UNIDX},
      '{aamc_pkg::KIND_VFP_LSM,   32'h0CA0_0000, 1'b0, aamc_pkg::MODE_UNKNOWN},
      '{aamc_pkg::KIND_VFP_LSM,   32'h0D20_0000, 1'b1, aamc_pkg::MODE_VFP_LSM_DEC},
      '{KIND_MAX,                 32'hFFFF_FFFF, 1'b1, aamc_pkg::MODE_UNKNOWN},
      '{KIND_FIRST_UNUSED,        32'h0200_0000, 1'b1, aamc_pkg::MODE_UNKNOWN}
    };

    // hold reset, then release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      drive_request(directed_rows[i].kind, directed_rows[i].word, directed_rows[i].typed,
                    directed_rows[i].mode, $urandom_range(0, MAX_GAP));
    end

    // drain before the random part
    start <= 1'b0;
    do @(negedge clk); while (expected_modes.size() != 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // pick a back-to-back stretch now and then
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);

      // drain the pipeline at a few points along the run
      if (i > 0 && i % DRAIN_EVERY == 0) begin
        start <= 1'b0;
        do @(negedge clk); while (expected_modes.size() != 0);
      end

      k = ($urandom_range(0, 9) == 0) ? aamc_pkg::KIND_W'($urandom_range(10, 15))
                                      : aamc_pkg::KIND_W'($urandom_range(0, 9));
      w = $urandom();

      // mostly land inside the class so the deeper fields matter
      if ($urandom_range(0, 9) < 8) begin
        case (k)
          aamc_pkg::KIND_DATA: begin
            w[27:26] = 2'b00;
            if ($urandom_range(0, 3) != 0) w[25] = 1'b0;
            case ($urandom_range(0, 5))
              0: w[11:4] = DP_RRX_FIELD;
              1: w[11:4] = 8'd0;
              2: w[7] = 1'b0;
              default: ;
            endcase
          end
          aamc_pkg::KIND_LS: begin
            w[27:26] = 2'b01;
            case ($urandom_range(0, 3))
              0: w[11:4] = 8'd0;
              1: w[4] = 1'b0;
              2: begin
                w[4] = 1'b0;
                w[11:7] = 5'd0;
              end
              default: ;
            endcase
          end
          aamc_pkg::KIND_LSM:    w[27:25] = aamc_pkg::LSM_CLASS_PAT;
          aamc_pkg::KIND_MISC: begin
            w[27:25] = 3'b000;
            w[7] = 1'b1;
            w[4] = 1'b1;
          end
          aamc_pkg::KIND_COPROC: w[27:25] = aamc_pkg::CP_CLASS_PAT;
          aamc_pkg::KIND_VFP_S, aamc_pkg::KIND_VFP_S_MON,
          aamc_pkg::KIND_VFP_D, aamc_pkg::KIND_VFP_D_MON: begin
            if ($urandom_range(0, 3) == 0) w[15:14] = 2'b00;
            if ($urandom_range(0, 3) == 0) w[3:2] = 2'b00;
          end
          aamc_pkg::KIND_VFP_LSM: begin
            w[27:23] = $urandom_range(0, 1) ? aamc_pkg::VFP_LSM_INC_PAT
                                            : aamc_pkg::VFP_LSM_DEC_PAT;
          end
          default: ;
        endcase
      end

      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      drive_request(k, w, 1'b0, aamc_pkg::MODE_UNKNOWN, gap);
    end

    // drop start, let the last results land, then a short tail
    start <= 1'b0;
    do @(negedge clk); while (expected_modes.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_modes.size() == 0) begin
      $display("arm_addressing_mode_classifier_unit_test: clean");
    end else begin
      $display("arm_addressing_mode_classifier_unit_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aamc_pkg.sv
rtl/aamc_decode.sv
rtl/arm_addressing_mode_classifier_unit.sv
bench/arm_addressing_mode_classifier_unit_test.sv
